>>> rtl/u8xv_pkg.sv
package u8xv_pkg;

	localparam int unsigned COUNT_W = 21;
	localparam int unsigned MAX_W   = 20;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_SAT     = 21'h100000;
	localparam logic [MAX_W-1:0]   MAX_RESET     = 20'h10000;
	localparam logic               REG_MAX_BYTES = 1'b0;

	localparam logic [7:0] LEAD1_END = 8'h80;
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;

	localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_NONCHAR0 = 21'h00FFFE;
	localparam logic [CP_W-1:0] CP_NONCHAR1 = 21'h00FFFF;
	localparam logic [CP_W-1:0] CP_SPACE    = 21'h000020;
	localparam logic [CP_W-1:0] CP_TAB      = 21'h000009;
	localparam logic [CP_W-1:0] CP_LF       = 21'h00000A;
	localparam logic [CP_W-1:0] CP_CR       = 21'h00000D;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_TOO_LONG  = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_BAD_CHAR  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_2B   = 2'd1,
		CLS_3B   = 2'd2,
		CLS_4B   = 2'd3
	} min_class_t;

	function automatic logic char_ok(logic [CP_W-1:0] cp, min_class_t cls);
		logic [CP_W-1:0] minimum;
		logic ok;
		unique case (cls)
			CLS_NONE: minimum = '0;
			CLS_2B:   minimum = CP_MIN_2B;
			CLS_3B:   minimum = CP_MIN_3B;
			CLS_4B:   minimum = CP_MIN_4B;
			default:  minimum = '0;
		endcase
		ok = 1'b1;
		if (cp < minimum) ok = 1'b0;
		if (cp > CP_MAX) ok = 1'b0;
		if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ok = 1'b0;
		if (cp < CP_SPACE && cp != CP_TAB && cp != CP_LF && cp != CP_CR) ok = 1'b0;
		if (cp == CP_NONCHAR0 || cp == CP_NONCHAR1) ok = 1'b0;
		return ok;
	endfunction

endpackage

>>> rtl/u8xv_in_if.sv
interface u8xv_in_if;
	import u8xv_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink (input valid, data_byte, has_byte, last, output ready);

endinterface

>>> rtl/u8xv_out_if.sv
interface u8xv_out_if;
	import u8xv_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [COUNT_W-1:0] field_bytes;

	modport source (output valid, status, field_bytes, input ready);
	modport sink (input valid, status, field_bytes, output ready);

endinterface

>>> rtl/utf8_xml_char_validator.sv
// Streaming UTF-8 and XML character check for one text field, one byte beat per clock.
// Each accepted beat is registered, decoded against the field state and, on the field's
// last beat, a status and saturated byte count land in the result register as that beat
// leaves the input register; input is taken every cycle unless a field's last beat is
// held behind a result the sink has not yet taken, so the rate is one beat per cycle, set by
// the single decode step between the input and result registers. Status: 0 valid, 1 too
// long (count above max_field_bytes, overrides any other error), 2 malformed UTF-8,
// 3 disallowed character. The first error in a field is kept; max_field_bytes is at APB
// byte address 0, reset 65536.
module utf8_xml_char_validator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [u8xv_pkg::ADDR_W-1:0] paddr,
	input  logic [u8xv_pkg::DATA_W-1:0] pwdata,
	output logic [u8xv_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	u8xv_in_if.sink                     bytes,
	u8xv_out_if.source                  result
);
	import u8xv_pkg::*;

	logic [MAX_W-1:0] max_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;

	logic [1:0]         pend_q;
	logic [CP_W-1:0]    cp_q;
	min_class_t         cls_q;
	logic [COUNT_W-1:0] cnt_q;
	status_t            err_q;

	logic [1:0]         pend_n;
	logic [CP_W-1:0]    cp_n;
	min_class_t         cls_n;
	logic [COUNT_W-1:0] cnt_n;
	status_t            err_n;
	status_t            fin_err;
	status_t            fin_status;
	logic [CP_W-1:0]    cp_shift;

	logic               res_valid_q;
	status_t            res_status_q;
	logic [COUNT_W-1:0] res_bytes_q;

	logic out_free;
	logic adv_s1;
	logic cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MAX_BYTES);
	assign prdata = (paddr[ADDR_W-1] == REG_MAX_BYTES) ?
		{{(DATA_W-MAX_W){1'b0}}, max_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_wr) begin
			max_q <= pwdata[MAX_W-1:0];
		end
	end

	// handshake
	assign out_free    = !res_valid_q || result.ready;
	assign adv_s1      = valid_s1 && (!last_s1 || out_free);
	assign bytes.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			has_s1  <= bytes.has_byte;
			last_s1 <= bytes.last;
		end
	end

	// decode
	always_comb begin
		pend_n   = pend_q;
		cp_n     = cp_q;
		cls_n    = cls_q;
		cnt_n    = cnt_q;
		err_n    = err_q;
		cp_shift = {cp_q[CP_W-7:0], byte_s1[5:0]};
		if (has_s1) begin
			if (cnt_q < COUNT_SAT) cnt_n = cnt_q + 1'b1;
			if (err_q == ST_VALID) begin
				if (pend_q == 2'd0) begin
					priority if (byte_s1 < LEAD1_END) begin
						if (!char_ok({{(CP_W-8){1'b0}}, byte_s1}, CLS_NONE)) err_n = ST_BAD_CHAR;
					end else if (byte_s1 >= LEAD2_MIN && byte_s1 <= LEAD2_MAX) begin
						pend_n = 2'd1;
						cp_n   = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
						cls_n  = CLS_2B;
					end else if (byte_s1 >= LEAD3_MIN && byte_s1 <= LEAD3_MAX) begin
						pend_n = 2'd2;
						cp_n   = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
						cls_n  = CLS_3B;
					end else if (byte_s1 >= LEAD4_MIN && byte_s1 <= LEAD4_MAX) begin
						pend_n = 2'd3;
						cp_n   = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
						cls_n  = CLS_4B;
					end else begin
						err_n = ST_MALFORMED;
					end
				end else if (byte_s1[7:6] != 2'b10) begin
					err_n = ST_MALFORMED;
				end else begin
					pend_n = pend_q - 2'd1;
					cp_n   = cp_shift;
					if (pend_n == 2'd0) begin
						if (!char_ok(cp_shift, cls_q)) err_n = ST_BAD_CHAR;
						cp_n  = '0;
						cls_n = CLS_NONE;
					end
				end
			end
		end
		fin_err = err_n;
		if (err_n == ST_VALID && pend_n != 2'd0) fin_err = ST_MALFORMED;
		fin_status = (cnt_n > {1'b0, max_q}) ? ST_TOO_LONG : fin_err;
	end

	// field state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 2'd0;
			cp_q        <= '0;
			cls_q       <= CLS_NONE;
			cnt_q       <= '0;
			err_q       <= ST_VALID;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				if (last_s1) begin
					pend_q <= 2'd0;
					cp_q   <= '0;
					cls_q  <= CLS_NONE;
					cnt_q  <= '0;
					err_q  <= ST_VALID;
				end else begin
					pend_q <= pend_n;
					cp_q   <= cp_n;
					cls_q  <= cls_n;
					cnt_q  <= cnt_n;
					err_q  <= err_n;
				end
			end
			if (adv_s1 && last_s1) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_status_q <= fin_status;
			res_bytes_q  <= cnt_n;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.status      = res_status_q;
	assign result.field_bytes = res_bytes_q;

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result raised without a last beat");

	a_field_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (cnt_q == '0 && pend_q == 2'd0 && err_q == ST_VALID))
		else $error("field state not cleared after last beat");

	a_seq_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= cls_q) && (pend_q != 2'd0 || (cls_q == CLS_NONE && cp_q == '0)))
		else $error("sequence state inconsistent");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_VALID && !(adv_s1 && last_s1)) |=> $stable(err_q))
		else $error("kept error changed within field");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_SAT)
		else $error("byte count beyond saturation");

endmodule

>>> test/tb_utf8_xml_char_validator.sv
`timescale 1ns / 1ps

module tb_utf8_xml_char_validator;
	import u8xv_pkg::*;

	localparam logic [ADDR_W-1:0] MAX_BYTES_ADDR = 3'd0;
	localparam logic [ADDR_W-1:0] SPARE_ADDR     = 3'd4;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] field_bytes;
	} field_result_t;

	typedef struct packed {
		logic [7:0]    data_byte;
		logic          has_byte;
		logic          last;
		logic          typed;
		field_result_t verdict;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	u8xv_in_if  byte_ch ();
	u8xv_out_if result_ch ();

	utf8_xml_char_validator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bytes   (byte_ch),
		.result  (result_ch)
	);

	stim_row_t directed_rows [27] = '{
		'{8'h00, 1'b1, 1'b1, 1'b1, '{ST_BAD_CHAR,  21'd1}},
		'{8'h5A, 1'b0, 1'b1, 1'b1, '{ST_VALID,     21'd0}},
		'{8'h09, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h0A, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h0D, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h7F, 1'b1, 1'b1, 1'b0, '{ST_VALID,     21'd0}},
		'{8'hFF, 1'b1, 1'b1, 1'b1, '{ST_MALFORMED, 21'd1}},
		'{8'hC2, 1'b1, 1'b1, 1'b1, '{ST_MALFORMED, 21'd1}},
		'{8'hC0, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b1, 1'b1, '{ST_MALFORMED, 21'd2}},
		'{8'hE0, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b1, 1'b1, '{ST_BAD_CHAR,  21'd3}},
		'{8'hED, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'hA0, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h00, 1'b0, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b1, 1'b0, '{ST_VALID,     21'd0}},
		'{8'hF4, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h90, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b1, 1'b0, '{ST_VALID,     21'd0}},
		'{8'hC2, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h41, 1'b1, 1'b1, 1'b0, '{ST_VALID,     21'd0}},
		'{8'hF0, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h9F, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h98, 1'b1, 1'b0, 1'b0, '{ST_VALID,     21'd0}},
		'{8'h80, 1'b1, 1'b1, 1'b0, '{ST_VALID,     21'd0}}
	};

	logic [1:0]         pend_cont;
	logic [CP_W-1:0]    cp_acc;
	min_class_t         cp_floor;
	logic [COUNT_W-1:0] byte_cnt;
	status_t            field_err;
	logic [MAX_W-1:0]   max_bytes;

	field_result_t due_verdicts [$];
	logic [7:0]    text_bytes [$];

	int src_idle;
	int snk_idle;
	int failures;
	int beats_sent;
	int verdicts_checked;
	int reg_writes;
	int stall_cycles;
	int status_seen [4];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit legal_char(logic [CP_W-1:0] cp, min_class_t cls);
		logic [CP_W-1:0] floor_cp;
		case (cls)
			CLS_2B:  floor_cp = 21'h000080;
			CLS_3B:  floor_cp = 21'h000800;
			CLS_4B:  floor_cp = 21'h010000;
			default: floor_cp = '0;
		endcase
		return !(cp < floor_cp || cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF)
			|| (cp < 21'h20 && cp != 21'h09 && cp != 21'h0A && cp != 21'h0D)
			|| cp == 21'h00FFFE || cp == 21'h00FFFF);
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic decode_beat(input logic [7:0] b, input logic h, input logic l,
			input logic typed, input field_result_t verdict);
		field_result_t res;
		if (h) begin
			if (byte_cnt < COUNT_SAT) begin
				byte_cnt++;
			end
			if (field_err == ST_VALID) begin
				if (pend_cont == 2'd0) begin
					if (b < 8'h80) begin
						if (!legal_char({13'd0, b}, CLS_NONE)) begin
							field_err = ST_BAD_CHAR;
						end
					end else if (b >= 8'hC2 && b <= 8'hDF) begin
						pend_cont = 2'd1;
						cp_acc = {16'd0, b[4:0]};
						cp_floor = CLS_2B;
					end else if (b >= 8'hE0 && b <= 8'hEF) begin
						pend_cont = 2'd2;
						cp_acc = {17'd0, b[3:0]};
						cp_floor = CLS_3B;
					end else if (b >= 8'hF0 && b <= 8'hF4) begin
						pend_cont = 2'd3;
						cp_acc = {18'd0, b[2:0]};
						cp_floor = CLS_4B;
					end else begin
						field_err = ST_MALFORMED;
					end
				end else if (b[7:6] != 2'b10) begin
					field_err = ST_MALFORMED;
				end else begin
					cp_acc = {cp_acc[14:0], b[5:0]};
					pend_cont--;
					if (pend_cont == 2'd0) begin
						if (!legal_char(cp_acc, cp_floor)) begin
							field_err = ST_BAD_CHAR;
						end
						cp_acc = '0;
						cp_floor = CLS_NONE;
					end
				end
			end
		end
		if (l) begin
			if (field_err == ST_VALID && pend_cont != 2'd0) begin
				field_err = ST_MALFORMED;
			end
			res.status = (byte_cnt > {1'b0, max_bytes}) ? ST_TOO_LONG : field_err;
			res.field_bytes = byte_cnt;
			due_verdicts.insert(due_verdicts.size(), typed ? verdict : res);
			pend_cont = 2'd0;
			cp_acc = '0;
			cp_floor = CLS_NONE;
			byte_cnt = '0;
			field_err = ST_VALID;
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic h, input logic l,
			input logic typed, input field_result_t verdict);
		while ($urandom_range(99) < src_idle) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.has_byte  <= h;
		byte_ch.last      <= l;
		@(negedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		if (h || l) begin
			beats_sent++;
		end
		decode_beat(b, h, l, typed, verdict);
	endtask

	task automatic wait_for_verdicts();
		byte_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (due_verdicts.size() != 0);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == MAX_BYTES_ADDR) begin
			max_bytes = data[MAX_W-1:0];
		end
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endtask

	task automatic push_code_point(input logic [CP_W-1:0] cp, input int len);
		case (len)
			1: queue_byte({1'b0, cp[6:0]});
			2: begin
				queue_byte({3'b110, cp[10:6]});
				queue_byte({2'b10, cp[5:0]});
			end
			3: begin
				queue_byte({4'b1110, cp[15:12]});
				queue_byte({2'b10, cp[11:6]});
				queue_byte({2'b10, cp[5:0]});
			end
			default: begin
				queue_byte({5'b11110, cp[20:18]});
				queue_byte({2'b10, cp[17:12]});
				queue_byte({2'b10, cp[11:6]});
				queue_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic send_random_field(input bit clean);
		int         n_chars;
		int         kind;
		int         len;
		bit         end_on_byte;
		logic [7:0] b;
		text_bytes.delete();
		n_chars = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(6);
		repeat (n_chars) begin
			kind = clean ? $urandom_range(72) : $urandom_range(99);
			if (kind < 30) begin
				push_code_point(CP_W'($urandom_range(8'h7E, 8'h20)), 1);
			end else if (kind < 38) begin
				push_code_point(($urandom_range(5) == 0) ? 21'h7F : CP_W'($urandom_range(31)), 1);
			end else if (kind < 53) begin
				push_code_point(CP_W'($urandom_range(21'h7FF, 21'h80)), 2);
			end else if (kind < 65) begin
				push_code_point(CP_W'($urandom_range(21'hFFFF, 21'h800)), 3);
			end else if (kind < 73) begin
				push_code_point(CP_W'($urandom_range(21'h10FFFF, 21'h10000)), 4);
			end else if (kind < 77) begin
				if ($urandom_range(1) == 0) begin
					push_code_point(CP_W'($urandom_range(21'hDFFF, 21'hD800)), 3);
				end else begin
					push_code_point(21'hFFFE | CP_W'($urandom_range(1)), 3);
				end
			end else if (kind < 82) begin
				len = $urandom_range(4, 2);
				push_code_point(CP_W'($urandom_range((len == 2) ? 'h7F : (len == 3) ? 'h7FF
					: 'hFFFF)), len);
			end else if (kind < 86) begin
				push_code_point(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
			end else if (kind < 92) begin
				queue_byte(8'($urandom_range(255)));
			end else if (kind < 96) begin
				len = $urandom_range(4, 2);
				push_code_point(CP_W'($urandom_range(21'h1FFFFF)), len);
				repeat ($urandom_range(len - 1, 1)) begin
					void'(text_bytes.pop_back());
				end
			end else begin
				queue_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
		end
		end_on_byte = (text_bytes.size() != 0) && ($urandom_range(9) < 7);
		while (text_bytes.size() != 0) begin
			if ($urandom_range(19) == 0) begin
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
			end
			b = text_bytes.pop_front();
			send_beat(b, 1'b1, end_on_byte && text_bytes.size() == 0, 1'b0, '0);
		end
		if (!end_on_byte) begin
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input logic [MAX_W-1:0] limit, input int src_pct, input int snk_pct,
			input int target, input bit poke_spare);
		int stop_at;
		wait_for_verdicts();
		repeat (4) @(posedge clk);
		apb_write(MAX_BYTES_ADDR, {{(DATA_W-MAX_W){1'b0}}, limit});
		if (poke_spare) begin
			apb_write(SPARE_ADDR, '0);
		end
		src_idle = src_pct;
		snk_idle = snk_pct;
		stop_at = beats_sent + target;
		while (beats_sent < stop_at) begin
			if ($urandom_range(29) == 0) begin
				wait_for_verdicts();
			end
			send_random_field($urandom_range(9) < 7);
		end
	endtask

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(negedge clk) begin
		field_result_t exp_res;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_verdicts.size() == 0) begin
				note_failure($sformatf("%0t: unexpected result, status %0d count %0d", $time,
					result_ch.status, result_ch.field_bytes));
			end else begin
				exp_res = due_verdicts.pop_front();
				verdicts_checked++;
				status_seen[exp_res.status]++;
				if (result_ch.status !== exp_res.status
						|| result_ch.field_bytes !== exp_res.field_bytes) begin
					note_failure($sformatf(
						"%0t: status %0d count %0d, expected status %0d count %0d", $time,
						result_ch.status, result_ch.field_bytes, exp_res.status,
						exp_res.field_bytes));
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, due_verdicts.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.has_byte  = 1'b0;
		byte_ch.last      = 1'b0;
		result_ch.ready   = 1'b0;
		pend_cont         = 2'd0;
		cp_acc            = '0;
		cp_floor          = CLS_NONE;
		byte_cnt          = '0;
		field_err         = ST_VALID;
		max_bytes         = MAX_RESET;
		src_idle          = 37;
		snk_idle          = 70;
		failures          = 0;
		beats_sent        = 0;
		verdicts_checked  = 0;
		reg_writes        = 0;
		stall_cycles      = 0;
		status_seen       = '{0, 0, 0, 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].data_byte, directed_rows[i].has_byte,
				directed_rows[i].last, directed_rows[i].typed, directed_rows[i].verdict);
		end

		run_phase(20'd6, 37, 70, 350, 1'b0);
		run_phase(20'd0, 70, 37, 200, 1'b0);
		run_phase(MAX_W'($urandom_range(12, 1)), 70, 37, 350, 1'b0);
		run_phase(20'hFFFFF, 0, 0, 500, 1'b1);
		run_phase(MAX_RESET, 0, 0, 150, 1'b0);

		wait_for_verdicts();
		repeat (8) @(posedge clk);

		$display("%0d beats sent, %0d field results checked, %0d register writes",
			beats_sent, verdicts_checked, reg_writes);
		$display("results: %0d valid, %0d too long, %0d malformed, %0d bad char; %0d failures",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], failures);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
